### hw/rtl/key_chord_input_gate_assert.svh
// Assertion macros shared by the key chord gate RTL.
`ifndef KEY_CHORD_INPUT_GATE_ASSERT_SVH
`define KEY_CHORD_INPUT_GATE_ASSERT_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define KCG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("key chord gate: same-cycle check failed");

// Next-cycle implication, checked on clk_i outside reset.
`define KCG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("key chord gate: next-cycle check failed");

`endif

### hw/rtl/kcg_pkg.sv
// Types and constants of the key chord input gate.
package kcg_pkg;

  localparam int NUM_KEYS = 64;
  localparam int KEY_AW   = $clog2(NUM_KEYS);
  localparam int MAP_W    = 64;
  localparam int CNT_W    = 8;
  localparam int CFG_IW   = 1;

  typedef logic [4:0]          ev_type_t;
  typedef logic [9:0]          key_code_t;
  typedef logic signed [31:0]  ev_value_t;
  typedef logic [KEY_AW-1:0]   key_addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [MAP_W-1:0]    map_t;
  typedef logic [CFG_IW-1:0]   cfg_idx_t;

  localparam ev_type_t EV_SYN = 5'd0;
  localparam ev_type_t EV_KEY = 5'd1;

  localparam ev_value_t VAL_RELEASE = 32'sd0;
  localparam ev_value_t VAL_PRESS   = 32'sd1;

  localparam cfg_idx_t CFG_CHORD_ON  = 1'b0;
  localparam cfg_idx_t CFG_CHORD_OFF = 1'b1;

endpackage

### hw/rtl/kcg_if.sv
// Valid/ready channel interfaces for input events and gate results.
interface kcg_ev_if;
  import kcg_pkg::*;
  logic      valid;
  logic      ready;
  ev_type_t  event_type;
  key_code_t key_code;
  ev_value_t event_value;
  modport source (output valid, event_type, key_code, event_value, input ready);
  modport sink   (input valid, event_type, key_code, event_value, output ready);
endinterface

interface kcg_res_if;
  logic valid;
  logic ready;
  logic forward_event;
  logic gate_active;
  logic code_out_of_range;
  modport source (output valid, forward_event, gate_active, code_out_of_range,
                  input ready);
  modport sink   (input valid, forward_event, gate_active, code_out_of_range,
                  output ready);
endinterface

### hw/rtl/key_chord_input_gate.sv
// Key chord input gate: per-key press counts in RAM, pressed map and gate flag.
//
// Channels: ev_i takes one input event request (type, code, value) per
// valid/ready handshake; res_o returns exactly one result request per event
// (forward_event, gate_active, code_out_of_range), in order. cfg_we_i writes
// chord_on_mask (index 0) or chord_off_mask (index 1); write
// only while no event is in flight.
// Path: an accepted event is held in the update stage, then its result in the output register.
// Throughput: one event per cycle unless res_o stalls, set by the single
// read-modify-write of the press count RAM (read at accept, written back by
// the update stage); a same-key event right behind gets the new count forwarded.
// Reset: gate inactive, pressed map clear, masks zero; per-key valid flops
// make every count read as zero, so no clearing pass is needed.
// Stall: a result waits in the output register while res_o.ready is low; one
// more event can be accepted and held in the update stage behind it, and
// ev_i.ready drops only when both are full.
module key_chord_input_gate (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  kcg_pkg::cfg_idx_t   cfg_idx_i,
  input  kcg_pkg::map_t       cfg_data_i,
  kcg_ev_if.sink              ev_i,
  kcg_res_if.source           res_o
);
  import kcg_pkg::*;

  `include "key_chord_input_gate_assert.svh"

  // configuration
  map_t chord_on_q, chord_off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chord_on_q  <= '0;
      chord_off_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CHORD_ON:  chord_on_q  <= cfg_data_i;
        CFG_CHORD_OFF: chord_off_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake control
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic s1_adv, in_acc;

  assign s1_adv = s1_valid_q && (!out_valid_q || res_o.ready);
  assign ev_i.ready = !s1_valid_q || s1_adv;
  assign in_acc = ev_i.valid && ev_i.ready;

  // decode at accept
  logic      is_key, dec_press, dec_release, dec_oor, dec_sync, dec_upd;
  key_addr_t rd_addr;

  always_comb begin
    is_key      = (ev_i.event_type == EV_KEY);
    dec_press   = is_key && (ev_i.event_value == VAL_PRESS);
    dec_release = is_key && (ev_i.event_value == VAL_RELEASE);
    dec_oor     = is_key && (ev_i.key_code >= 10'(NUM_KEYS));
    dec_sync    = (ev_i.event_type == EV_SYN);
    dec_upd     = (dec_press || dec_release) && !dec_oor;
    rd_addr     = ev_i.key_code[KEY_AW-1:0];
  end

  // update stage registers
  logic      s1_press_q, s1_release_q, s1_oor_q, s1_sync_q, s1_upd_q;
  key_addr_t s1_addr_q;

  // press count RAM, read at accept, written from the update stage
  cnt_t                mem [NUM_KEYS];
  cnt_t                rd_data_q;
  logic [NUM_KEYS-1:0] cnt_valid_q;
  logic                wr_en;
  cnt_t                wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[s1_addr_q] <= wr_data;
    if (in_acc) rd_data_q <= mem[rd_addr];
  end

  // forward a count written in the same edge as the read of that key
  logic fwd_hit_q;
  cnt_t fwd_data_q;

  // pressed map and gate flag
  map_t pressed_q, pressed_d;
  logic gate_q, gate_d;

  // result register
  logic res_fwd_q, res_gate_q, res_oor_q;

  always_comb begin
    cnt_t cnt_old;
    map_t bit_sel;
    logic chk;
    cnt_old = fwd_hit_q ? fwd_data_q : (cnt_valid_q[s1_addr_q] ? rd_data_q : '0);
    if (s1_press_q) begin
      wr_data = cnt_old + 1'b1;
    end else if (cnt_old == '0) begin
      wr_data = '0;
    end else begin
      wr_data = cnt_old - 1'b1;
    end
    bit_sel   = MAP_W'(1) << s1_addr_q;
    pressed_d = pressed_q;
    gate_d    = gate_q;
    chk       = 1'b0;
    if (s1_upd_q) begin
      if (s1_press_q) begin
        pressed_d = pressed_q | bit_sel;
        chk       = 1'b1;
      end else if (wr_data == '0) begin
        pressed_d = pressed_q & ~bit_sel;
        chk       = 1'b1;
      end
    end
    if (chk) begin
      if (gate_q) begin
        gate_d = (pressed_d != chord_off_q);
      end else begin
        gate_d = s1_press_q && ((chord_on_q & pressed_d) == chord_on_q);
      end
    end
    wr_en = s1_adv && s1_upd_q;
  end

  always_comb begin
    s1_valid_d = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = s1_adv ? 1'b1 : (res_o.ready ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_valid_q <= '0;
      fwd_hit_q   <= 1'b0;
      pressed_q   <= '0;
      gate_q      <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (wr_en) cnt_valid_q[s1_addr_q] <= 1'b1;
      if (in_acc) fwd_hit_q <= wr_en && (s1_addr_q == rd_addr);
      if (s1_adv) begin
        pressed_q <= pressed_d;
        gate_q    <= gate_d;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_press_q   <= dec_press;
      s1_release_q <= dec_release;
      s1_oor_q     <= dec_oor;
      s1_sync_q    <= dec_sync;
      s1_upd_q     <= dec_upd;
      s1_addr_q    <= rd_addr;
      fwd_data_q   <= wr_data;
    end
    if (s1_adv) begin
      res_fwd_q  <= !gate_d || s1_sync_q || s1_release_q;
      res_gate_q <= gate_d;
      res_oor_q  <= s1_oor_q;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.forward_event     = res_fwd_q;
  assign res_o.gate_active       = res_gate_q;
  assign res_o.code_out_of_range = res_oor_q;

  // checks
  `KCG_ASSERT_NEXT(a_accept_fills_stage, in_acc, s1_valid_q)
  `KCG_ASSERT_NOW(a_write_on_advance, wr_en, s1_adv && s1_valid_q)
  `KCG_ASSERT_NEXT(a_stall_holds_map, s1_valid_q && !s1_adv, $stable(pressed_q) && $stable(gate_q))
  `KCG_ASSERT_NOW(a_result_gate_current, out_valid_q, res_gate_q == gate_q)

endmodule
